// ===== design/pcci_pkg.sv =====
// shared constants, types and codes for the clamped-integral pid controller
// no dependencies; every other design file refers to it by scoped names

package pcci_pkg;

  // fixed-point format
  localparam int FRAC_BITS = 16;

  // field widths
  localparam int DATA_W  = 32;
  localparam int DT_W    = 24;
  localparam int LIMIT_W = 31;
  localparam int ERR_W   = DATA_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int DERIV_W = DATA_W + 1;

  // shared multiplier: a (signed) times one half of b per cycle
  localparam int A_W     = DERIV_W;
  localparam int B_W     = DATA_W;
  localparam int SPLIT_W = B_W / 2;
  localparam int PART_W  = SPLIT_W + 1;
  localparam int PROD_W  = A_W + PART_W;
  localparam int ACC_W   = A_W + B_W;

  // drive sum of three scaled products
  localparam int SUM_W = ACC_W - FRAC_BITS + 1;

  // serial divider for the derivative
  localparam int QUO_W     = DATA_W;
  localparam int DIV_STEPS = 2;
  localparam int DIV_ITER  = QUO_W / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_ITER);

  // configuration
  localparam int CFG_IDX_W = 2;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536000);

  // drive saturation bounds
  localparam logic signed [SUM_W-1:0] DRIVE_MAX = SUM_W'(signed'(32'h7FFF_FFFF));
  localparam logic signed [SUM_W-1:0] DRIVE_MIN = SUM_W'(signed'(32'h8000_0000));
  localparam logic signed [DATA_W-1:0] DRIVE_MAX_OUT = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] DRIVE_MIN_OUT = 32'sh8000_0000;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P    = 2'd0,
    CFG_GAIN_I    = 2'd1,
    CFG_GAIN_D    = 2'd2,
    CFG_INT_LIMIT = 2'd3
  } cfg_idx_e;

  // which product the multiplier is working on
  typedef enum logic [1:0] {
    TAG_INT = 2'd0,
    TAG_KP  = 2'd1,
    TAG_KI  = 2'd2,
    TAG_KD  = 2'd3
  } mac_tag_e;

  typedef struct packed {
    logic     vld;
    logic     hi;
    mac_tag_e tag;
  } mac_op_t;

  typedef struct packed {
    logic     done;
    mac_tag_e tag;
  } mac_rsp_t;

endpackage

// ===== design/pcci_in_if.sv =====
// input request channel: setpoint, measurement and time step
// depends on pcci_pkg for field widths

interface pcci_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcci_pkg::DATA_W-1:0] setpoint;
  logic signed [pcci_pkg::DATA_W-1:0] measurement;
  logic        [pcci_pkg::DT_W-1:0]   time_step;

  modport source (output valid, setpoint, measurement, time_step, input ready);
  modport sink   (input valid, setpoint, measurement, time_step, output ready);
endinterface

// ===== design/pcci_out_if.sv =====
// result channel: saturated drive value and its clip flag
// depends on pcci_pkg for field widths

interface pcci_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcci_pkg::DATA_W-1:0] drive;
  logic                                saturated;

  modport source (output valid, drive, saturated, input ready);
  modport sink   (input valid, drive, saturated, output ready);
endinterface

// ===== design/pcci_cfg_if.sv =====
// configuration write channel: register index and write data
// depends on pcci_pkg for widths

interface pcci_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pcci_pkg::CFG_IDX_W-1:0]   index;
  logic [pcci_pkg::DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/pcci_mac.sv =====
// shared multiply-accumulate unit: one half of b per cycle, low half then high half for each product
// depends on pcci_pkg for widths and the op/response structs

module pcci_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pcci_pkg::mac_op_t                    op_i,
  input  logic signed [pcci_pkg::A_W-1:0]     a_i,
  input  logic signed [pcci_pkg::B_W-1:0]     b_i,
  output logic signed [pcci_pkg::ACC_W-1:0]   acc_o,
  output pcci_pkg::mac_rsp_t                   rsp_o
);

  logic signed [pcci_pkg::PART_W-1:0] part;
  logic signed [pcci_pkg::PROD_W-1:0] prod_d;
  logic signed [pcci_pkg::PROD_W-1:0] prod_q;
  logic                               prod_vld_q;
  logic                               prod_hi_q;
  pcci_pkg::mac_tag_e                 prod_tag_q;
  logic signed [pcci_pkg::ACC_W-1:0]  addend;
  logic signed [pcci_pkg::ACC_W-1:0]  base;
  logic signed [pcci_pkg::ACC_W-1:0]  acc_q;
  pcci_pkg::mac_rsp_t                 rsp_q;

  // low half is unsigned, high half carries the sign of b
  assign part = op_i.hi ?
      signed'({b_i[pcci_pkg::B_W-1], b_i[pcci_pkg::B_W-1:pcci_pkg::SPLIT_W]}) :
      signed'({1'b0, b_i[pcci_pkg::SPLIT_W-1:0]});

  assign prod_d = a_i * part;

  // partial product weighted into the accumulator, low half clears it
  assign addend = prod_hi_q ?
      (pcci_pkg::ACC_W'(prod_q) <<< pcci_pkg::SPLIT_W) : pcci_pkg::ACC_W'(prod_q);
  assign base   = prod_hi_q ? acc_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q     <= '0;
      prod_vld_q <= 1'b0;
      prod_hi_q  <= 1'b0;
      prod_tag_q <= pcci_pkg::TAG_INT;
      acc_q      <= '0;
      rsp_q      <= '0;
    end else begin
      prod_vld_q <= op_i.vld;
      if (op_i.vld) begin
        prod_q     <= prod_d;
        prod_hi_q  <= op_i.hi;
        prod_tag_q <= op_i.tag;
      end
      rsp_q.done <= prod_vld_q && prod_hi_q;
      if (prod_vld_q) begin
        acc_q     <= base + addend;
        rsp_q.tag <= prod_tag_q;
      end
    end
  end

  assign acc_o = acc_q;
  assign rsp_o = rsp_q;

endmodule

// ===== design/pcci_div.sv =====
// serial divider for the derivative: (diff << FRAC_BITS) / time_step, truncated
// two quotient bits per cycle, result clipped to +-(2^32 - 1); depends on pcci_pkg

module pcci_div (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [pcci_pkg::DIFF_W-1:0]    diff_i,
  input  logic        [pcci_pkg::DT_W-1:0]      dt_i,
  output logic                                   vld_o,
  output logic signed [pcci_pkg::DERIV_W-1:0]   quot_o
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_PREP,
    D_ITER,
    D_FIN
  } div_state_e;

  div_state_e                          state_q;
  logic                                neg_q;
  logic                                sat_q;
  logic [pcci_pkg::DIFF_W-1:0]         mag_q;
  logic [pcci_pkg::DT_W-1:0]           dt_q;
  logic [pcci_pkg::DT_W-1:0]           rem_q;
  logic [pcci_pkg::DT_W-1:0]           rem_d;
  logic [pcci_pkg::QUO_W-1:0]          num_q;
  logic [pcci_pkg::QUO_W-1:0]          num_d;
  logic [pcci_pkg::DIV_CNT_W-1:0]      cnt_q;
  logic                                vld_q;
  logic signed [pcci_pkg::DERIV_W-1:0] quot_q;
  logic [pcci_pkg::DIFF_W-1:0]         mag_hi;
  logic [pcci_pkg::DIFF_W+pcci_pkg::FRAC_BITS-1:0] mag_sh;
  logic [pcci_pkg::QUO_W-1:0]          mag_res;
  logic [pcci_pkg::DERIV_W-1:0]        mag_ext;

  // the part of the dividend above the quotient range; at or above the
  // divisor the quotient does not fit and is clipped
  assign mag_hi = mag_q >> (pcci_pkg::QUO_W - pcci_pkg::FRAC_BITS);
  assign mag_sh = {mag_q, {pcci_pkg::FRAC_BITS{1'b0}}};

  // restoring steps, quotient bits shift in where dividend bits leave
  always_comb begin
    logic [pcci_pkg::DT_W:0]    t;
    logic [pcci_pkg::DT_W-1:0]  r;
    logic [pcci_pkg::QUO_W-1:0] n;
    r = rem_q;
    n = num_q;
    for (int k = 0; k < pcci_pkg::DIV_STEPS; k++) begin
      t = {r, n[pcci_pkg::QUO_W-1]};
      n = {n[pcci_pkg::QUO_W-2:0], 1'b0};
      if (t >= {1'b0, dt_q}) begin
        t    = t - {1'b0, dt_q};
        n[0] = 1'b1;
      end
      r = t[pcci_pkg::DT_W-1:0];
    end
    rem_d = r;
    num_d = n;
  end

  assign mag_res = sat_q ? {pcci_pkg::QUO_W{1'b1}} : num_q;
  assign mag_ext = {1'b0, mag_res};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      neg_q   <= 1'b0;
      sat_q   <= 1'b0;
      mag_q   <= '0;
      dt_q    <= '0;
      rem_q   <= '0;
      num_q   <= '0;
      cnt_q   <= '0;
      vld_q   <= 1'b0;
      quot_q  <= '0;
    end else begin
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            neg_q   <= diff_i[pcci_pkg::DIFF_W-1];
            mag_q   <= diff_i[pcci_pkg::DIFF_W-1] ? 
                       pcci_pkg::DIFF_W'(-diff_i) : pcci_pkg::DIFF_W'(diff_i);
            dt_q    <= dt_i;
            vld_q   <= 1'b0;
            state_q <= D_PREP;
          end
        end
        D_PREP: begin
          sat_q <= 1'b0;
          cnt_q <= '0;
          if (dt_q == '0) begin
            // zero time step: derivative taken as zero
            num_q   <= '0;
            state_q <= D_FIN;
          end else if (mag_hi >= pcci_pkg::DIFF_W'(dt_q)) begin
            sat_q   <= 1'b1;
            state_q <= D_FIN;
          end else begin
            rem_q   <= mag_hi[pcci_pkg::DT_W-1:0];
            num_q   <= mag_sh[pcci_pkg::QUO_W-1:0];
            state_q <= D_ITER;
          end
        end
        D_ITER: begin
          rem_q <= rem_d;
          num_q <= num_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == pcci_pkg::DIV_CNT_W'(pcci_pkg::DIV_ITER - 1)) begin
            state_q <= D_FIN;
          end
        end
        D_FIN: begin
          quot_q  <= neg_q ? signed'(-mag_ext) : signed'(mag_ext);
          vld_q   <= 1'b1;
          state_q <= D_IDLE;
        end
        default: begin
          state_q <= D_IDLE;
        end
      endcase
    end
  end

  assign vld_o  = vld_q;
  assign quot_o = quot_q;

endmodule

// ===== design/pid_controller_clamped_integral.sv =====
// top level of the clamped-integral pid controller: sequencer, state and output register
// depends on pcci_pkg, the three channel interfaces, pcci_mac and pcci_div
//
// usage
//   in_i carries one request per control step: setpoint and measurement
//   (signed Q16.16) and the time step (unsigned Q8.16). out_o returns one
//   result per request: the drive value (signed Q16.16, clipped to 32 bits)
//   and a flag set when clipping took place.
//   cfg_i writes the gains and the integral limit; it is always ready and
//   writes should only be issued while no request is in flight.
// sequencing
//   requests are handled one at a time: in_i is ready again only once the
//   result is loaded into the output register, in the cycle that result
//   is first offered. the time to a result is set by the derivative divider
//   (two quotient bits per step) followed by the derivative gain product on
//   the shared multiplier: low half then high half of the gain, through its
//   product and accumulator registers. with a zero time step or a clipped
//   derivative the divider skips its iterations and finishes sooner.
// reset and stalls
//   reset clears the integral, the previous error and the output register,
//   zeroes the gains and sets the limit to 1000.0.
//   the result sits in an output register; if the receiver stalls, the
//   next request is still accepted and worked on, and waits at its final
//   step until the register has been emptied.

module pid_controller_clamped_integral (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcci_in_if.sink     in_i,
  pcci_out_if.source  out_o,
  pcci_cfg_if.sink    cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INT_LO,
    S_INT_HI,
    S_KP_LO,
    S_KP_HI,
    S_KI_LO,
    S_KI_HI,
    S_WAIT_DIV,
    S_KD_LO,
    S_KD_HI,
    S_WAIT_KD,
    S_SAT
  } seq_state_e;

  seq_state_e                                state_q;

  // configuration
  logic signed [pcci_pkg::DATA_W-1:0]       kp_q;
  logic signed [pcci_pkg::DATA_W-1:0]       ki_q;
  logic signed [pcci_pkg::DATA_W-1:0]       kd_q;
  logic        [pcci_pkg::LIMIT_W-1:0]      limit_q;

  // controller state and per-request values
  logic signed [pcci_pkg::DATA_W-1:0]       int_q;
  logic signed [pcci_pkg::ERR_W-1:0]        lerr_q;
  logic signed [pcci_pkg::ERR_W-1:0]        err_q;
  logic        [pcci_pkg::DT_W-1:0]         dt_q;
  logic signed [pcci_pkg::DIFF_W-1:0]       diff_q;
  logic signed [pcci_pkg::SUM_W-1:0]        sum_q;

  // output register
  logic                                      out_vld_q;
  logic signed [pcci_pkg::DATA_W-1:0]       drive_q;
  logic                                      sat_q;

  // shared units
  pcci_pkg::mac_op_t                         mac_op;
  logic signed [pcci_pkg::A_W-1:0]          mac_a;
  logic signed [pcci_pkg::B_W-1:0]          mac_b;
  logic signed [pcci_pkg::ACC_W-1:0]        mac_acc;
  pcci_pkg::mac_rsp_t                        mac_rsp;
  logic                                      div_start;
  logic                                      div_vld;
  logic signed [pcci_pkg::DERIV_W-1:0]      div_quot;

  logic signed [pcci_pkg::ACC_W-1:0]        acc_sh;
  logic signed [pcci_pkg::SUM_W-1:0]        term;
  logic signed [pcci_pkg::SUM_W-1:0]        int_sum;
  logic signed [pcci_pkg::SUM_W-1:0]        lim_pos;
  logic signed [pcci_pkg::SUM_W-1:0]        lim_neg;
  logic signed [pcci_pkg::DATA_W-1:0]      int_d;
  logic                                      out_free;

  // handshakes
  assign in_i.ready      = (state_q == S_IDLE);
  assign cfg_i.ready     = 1'b1;
  assign out_o.valid     = out_vld_q;
  assign out_o.drive     = drive_q;
  assign out_o.saturated = sat_q;
  assign out_free        = !out_vld_q || out_o.ready;

  // operand selection for the shared multiplier
  always_comb begin
    mac_op.vld = 1'b0;
    mac_op.hi  = 1'b0;
    mac_op.tag = pcci_pkg::TAG_INT;
    mac_a      = pcci_pkg::A_W'(err_q);
    mac_b      = pcci_pkg::B_W'(dt_q);
    case (state_q)
      S_INT_LO, S_INT_HI: begin
        mac_op.vld = 1'b1;
        mac_op.hi  = (state_q == S_INT_HI);
        mac_op.tag = pcci_pkg::TAG_INT;
      end
      S_KP_LO, S_KP_HI: begin
        mac_op.vld = 1'b1;
        mac_op.hi  = (state_q == S_KP_HI);
        mac_op.tag = pcci_pkg::TAG_KP;
        mac_b      = kp_q;
      end
      S_KI_LO, S_KI_HI: begin
        mac_op.vld = 1'b1;
        mac_op.hi  = (state_q == S_KI_HI);
        mac_op.tag = pcci_pkg::TAG_KI;
        mac_a      = pcci_pkg::A_W'(int_q);
        mac_b      = ki_q;
      end
      S_KD_LO, S_KD_HI: begin
        mac_op.vld = 1'b1;
        mac_op.hi  = (state_q == S_KD_HI);
        mac_op.tag = pcci_pkg::TAG_KD;
        mac_a      = pcci_pkg::A_W'(div_quot);
        mac_b      = kd_q;
      end
      default: begin
      end
    endcase
  end

  assign div_start = (state_q == S_INT_HI);

  pcci_mac u_pcci_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (mac_acc),
    .rsp_o  (mac_rsp)
  );

  pcci_div u_pcci_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .diff_i  (diff_q),
    .dt_i    (dt_q),
    .vld_o   (div_vld),
    .quot_o  (div_quot)
  );

  // finished product scaled down with floor rounding
  assign acc_sh = mac_acc >>> pcci_pkg::FRAC_BITS;
  assign term   = signed'(acc_sh[pcci_pkg::SUM_W-1:0]);

  // integral update and symmetric clamp
  assign int_sum = pcci_pkg::SUM_W'(int_q) + term;
  assign lim_pos = pcci_pkg::SUM_W'(signed'({1'b0, limit_q}));
  assign lim_neg = -lim_pos;

  always_comb begin
    if (int_sum > lim_pos) begin
      int_d = lim_pos[pcci_pkg::DATA_W-1:0];
    end else if (int_sum < lim_neg) begin
      int_d = lim_neg[pcci_pkg::DATA_W-1:0];
    end else begin
      int_d = int_sum[pcci_pkg::DATA_W-1:0];
    end
  end

  // sequencer, controller state, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      kp_q      <= '0;
      ki_q      <= '0;
      kd_q      <= '0;
      limit_q   <= pcci_pkg::LIMIT_RESET;
      int_q     <= '0;
      lerr_q    <= '0;
      err_q     <= '0;
      dt_q      <= '0;
      diff_q    <= '0;
      sum_q     <= '0;
      out_vld_q <= 1'b0;
      drive_q   <= '0;
      sat_q     <= 1'b0;
    end else begin
      // register writes
      if (cfg_i.valid) begin
        case (pcci_pkg::cfg_idx_e'(cfg_i.index))
          pcci_pkg::CFG_GAIN_P:    kp_q    <= signed'(cfg_i.data);
          pcci_pkg::CFG_GAIN_I:    ki_q    <= signed'(cfg_i.data);
          pcci_pkg::CFG_GAIN_D:    kd_q    <= signed'(cfg_i.data);
          pcci_pkg::CFG_INT_LIMIT: limit_q <= cfg_i.data[pcci_pkg::LIMIT_W-1:0];
          default: begin
          end
        endcase
      end

      // finished products from the shared multiplier
      if (mac_rsp.done) begin
        case (mac_rsp.tag)
          pcci_pkg::TAG_INT: int_q <= int_d;
          pcci_pkg::TAG_KP,
          pcci_pkg::TAG_KI,
          pcci_pkg::TAG_KD:  sum_q <= sum_q + term;
          default: begin
          end
        endcase
      end

      // result taken; a new one loaded in the same cycle is set below
      if (out_o.valid && out_o.ready && (state_q != S_SAT)) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            err_q   <= pcci_pkg::ERR_W'(in_i.setpoint) - pcci_pkg::ERR_W'(in_i.measurement);
            dt_q    <= in_i.time_step;
            sum_q   <= '0;
            state_q <= S_INT_LO;
          end
        end
        S_INT_LO: begin
          diff_q  <= pcci_pkg::DIFF_W'(err_q) - pcci_pkg::DIFF_W'(lerr_q);
          lerr_q  <= err_q;
          state_q <= S_INT_HI;
        end
        S_INT_HI:   state_q <= S_KP_LO;
        S_KP_LO:    state_q <= S_KP_HI;
        S_KP_HI:    state_q <= S_KI_LO;
        S_KI_LO:    state_q <= S_KI_HI;
        S_KI_HI:    state_q <= S_WAIT_DIV;
        S_WAIT_DIV: begin
          if (div_vld) begin
            state_q <= S_KD_LO;
          end
        end
        S_KD_LO:    state_q <= S_KD_HI;
        S_KD_HI:    state_q <= S_WAIT_KD;
        S_WAIT_KD: begin
          if (mac_rsp.done && (mac_rsp.tag == pcci_pkg::TAG_KD)) begin
            state_q <= S_SAT;
          end
        end
        S_SAT: begin
          // clip to 32 bits once the output register is free
          if (out_free) begin
            out_vld_q <= 1'b1;
            if (sum_q > pcci_pkg::DRIVE_MAX) begin
              drive_q <= pcci_pkg::DRIVE_MAX_OUT;
              sat_q   <= 1'b1;
            end else if (sum_q < pcci_pkg::DRIVE_MIN) begin
              drive_q <= pcci_pkg::DRIVE_MIN_OUT;
              sat_q   <= 1'b1;
            end else begin
              drive_q <= sum_q[pcci_pkg::DATA_W-1:0];
              sat_q   <= 1'b0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/pcci_checker.sv =====
// port-level checks for the clamped-integral pid controller, bound to the top level
// depends on pcci_pkg and the three channel interfaces

module pcci_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcci_in_if.sink     in_i,
  pcci_out_if.source  out_o,
  pcci_cfg_if.sink    cfg_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> $stable(out_o.drive) && $stable(out_o.saturated))
    else $error("result payload changed while stalled");

  // one request at a time: busy right after an acceptance
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("request accepted while busy");

  // the clip flag only comes with a rail value
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      (out_o.drive == pcci_pkg::DRIVE_MAX_OUT) || (out_o.drive == pcci_pkg::DRIVE_MIN_OUT))
    else $error("saturated flag without a rail value");

  // configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid |-> cfg_i.ready)
    else $error("configuration write stalled");

endmodule

bind pid_controller_clamped_integral pcci_checker u_pcci_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o),
  .cfg_i  (cfg_i)
);
